/* rtl/absa_pkg.sv */
// Shared types, constants and helpers of the aligned bitmap segment allocator.
package absa_pkg;

  localparam int NUM_SEGMENTS  = 4096;
  localparam int MAP_WORD_BITS = 64;
  localparam int ADDR_BITS     = 48;

  localparam int MAP_WORDS = (NUM_SEGMENTS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int SEG_W     = $clog2(NUM_SEGMENTS + 1);
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(MAP_WORD_BITS);
  localparam int LEN_W     = $clog2(SEG_W + 1);

  localparam int SHIFT_SMALL = 6;
  localparam int SHIFT_LARGE = 12;
  localparam int CAP_SMALL   = 6;
  localparam int CAP_LARGE   = 8;
  localparam int ALIGN_W     = CAP_LARGE;

  localparam int REQ_W   = 2;
  localparam int SIZE_W  = 40;
  localparam int FADDR_W = 48;
  localparam int BASE_W  = 42;
  localparam int CNT_W   = 13;
  localparam int WIDE_W  = BASE_W + SEG_W + SHIFT_LARGE;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_BAD_ADDR = 2'd3
  } status_t;

  localparam logic [1:0] CFG_IDX_GRANULE = 2'd0;
  localparam logic [1:0] CFG_IDX_BASE    = 2'd1;
  localparam logic [1:0] CFG_IDX_COUNT   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RD,
    S_LD,
    S_SCAN,
    S_SCAN_END,
    S_MRD,
    S_MLD,
    S_MWR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic rd;
    logic rd_mark;
    logic ld;
    logic scan;
    logic wr;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic chk_scan;
    logic chk_mark;
    logic scan_last;
    logic word_last;
    logic found;
    logic mark_last;
    logic out_free;
  } stat_t;

  // number of significant bits of x
  function automatic logic [LEN_W-1:0] bit_len(input logic [SEG_W-1:0] x);
    logic [LEN_W-1:0] r;
    r = '0;
    for (int i = 0; i < SEG_W; i++) begin
      if (x[i]) r = LEN_W'(i + 1);
    end
    return r;
  endfunction

endpackage

/* rtl/absa_if.sv */
// Request and response channel interfaces of the allocator.
interface absa_req_if import absa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [SIZE_W-1:0]  size_bytes;
  logic [FADDR_W-1:0] free_addr;
  modport source(output valid, req_type, size_bytes, free_addr, input ready);
  modport sink(input valid, req_type, size_bytes, free_addr, output ready);
endinterface

interface absa_rsp_if import absa_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [FADDR_W-1:0] alloc_addr;
  logic [SIZE_W-1:0]  largest_free_bytes;
  logic [SIZE_W-1:0]  free_bytes;
  modport source(output valid, status, alloc_addr, largest_free_bytes, free_bytes,
                 input ready);
  modport sink(input valid, status, alloc_addr, largest_free_bytes, free_bytes,
               output ready);
endinterface

/* rtl/aligned_bitmap_segment_allocator.sv */
// Top level of the aligned bitmap segment allocator.
//
// Usage:
//   in_if  : request word (req_type, size_bytes, free_addr), valid/ready.
//   out_if : one response word per request (status, alloc_addr,
//            largest_free_bytes, free_bytes), valid/ready.
//   cfg_*  : APB-style register port, 64-bit data, registers at 8*i:
//            large_granule, pool_base_segment, pool_segment_count.
// One request is worked at a time. Alloc and query walk the occupancy
// map one segment per cycle, pausing at each map word for a word fetch
// (read, load); the walk covers at most cnt segments (cnt = pool
// segments, at most 4096); alloc stops at the first fitting run.
// Alloc and free then rewrite each touched map word (read, load, write).
// Bad requests go from the check straight to the response.
// The segment-by-segment walk sets the pace; the next request is taken
// the cycle after the response is registered.
// Reset clears the map (per-word valid bits, no sweep), the used count
// and the registers. A response waits in the output register while the
// receiver stalls; the next request is taken meanwhile but its response
// holds until the output register frees.
module aligned_bitmap_segment_allocator import absa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  absa_req_if.sink           in_if,
  absa_rsp_if.source         out_if,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign cfg_pready  = 1'b1;
  assign in_if.ready = in_ready;

  // sequencer
  absa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // map, checks and result registers
  absa_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_psel               (cfg_psel),
    .cfg_penable            (cfg_penable),
    .cfg_pwrite             (cfg_pwrite),
    .cfg_paddr              (cfg_paddr),
    .cfg_pwdata             (cfg_pwdata),
    .cfg_prdata             (cfg_prdata),
    .in_req_type            (in_if.req_type),
    .in_size_bytes          (in_if.size_bytes),
    .in_free_addr           (in_if.free_addr),
    .out_ready              (out_if.ready),
    .out_valid              (out_if.valid),
    .out_status             (out_if.status),
    .out_alloc_addr         (out_if.alloc_addr),
    .out_largest_free_bytes (out_if.largest_free_bytes),
    .out_free_bytes         (out_if.free_bytes),
    .cmd                    (cmd),
    .stat                   (stat)
  );

  // a taken request blocks the next one until its work is done
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

endmodule

/* rtl/absa_ram.sv */
// Generic single-port-write, registered-read RAM.
module absa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* rtl/absa_ctrl.sv */
// Sequencer of the allocator: request checks, map scan, map update, response.
module absa_ctrl import absa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.chk_scan)      state_nxt = S_RD;
        else if (stat.chk_mark) state_nxt = S_MRD;
        else                    state_nxt = S_RESP;
      end
      S_RD:  state_nxt = S_LD;
      S_LD:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (stat.scan_last)      state_nxt = S_SCAN_END;
        else if (stat.word_last) state_nxt = S_RD;
      end
      S_SCAN_END: begin
        state_nxt = stat.found ? S_MRD : S_RESP;
      end
      S_MRD: state_nxt = S_MLD;
      S_MLD: state_nxt = S_MWR;
      S_MWR: begin
        state_nxt = stat.mark_last ? S_RESP : S_MRD;
      end
      S_RESP: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CHECK:    cmd.check   = 1'b1;
      S_RD:       cmd.rd      = 1'b1;
      S_LD:       cmd.ld      = 1'b1;
      S_SCAN:     cmd.scan    = 1'b1;
      S_SCAN_END: cmd         = '0;
      S_MRD:      cmd.rd_mark = 1'b1;
      S_MLD:      cmd.ld      = 1'b1;
      S_MWR:      cmd.wr      = 1'b1;
      S_RESP:     cmd.fin     = stat.out_free;
      default:    cmd         = '0;
    endcase
  end

endmodule

/* rtl/absa_dp.sv */
// Datapath: config registers, occupancy map, scan and run evaluation, result registers.
module absa_dp import absa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // config port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  // request word
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [SIZE_W-1:0]  in_size_bytes,
  input  logic [FADDR_W-1:0] in_free_addr,
  // response word
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [FADDR_W-1:0] out_alloc_addr,
  output logic [SIZE_W-1:0]  out_largest_free_bytes,
  output logic [SIZE_W-1:0]  out_free_bytes,
  // control
  input  cmd_t               cmd,
  output stat_t              stat
);

  // config
  logic              granule_r;
  logic [BASE_W-1:0] base_r;
  logic [CNT_W-1:0]  count_r;

  // request
  req_t               req_r;
  logic [SIZE_W-1:0]  size_r;
  logic [FADDR_W-1:0] addr_r;

  // allocator state
  logic [SEG_W-1:0] used_r;

  // work registers
  status_t            stat_r;
  logic [SEG_W-1:0]   n_r, lo_r, hi_r, p_r, start_r, best_r;
  logic [ALIGN_W-1:0] amask_r, offs_r;
  logic               run_r, found_r;
  logic [WIDX_W-1:0]  w_r;
  logic [MAP_WORD_BITS-1:0] word_r;

  // run evaluation stage
  logic             ev_v_r;
  logic [SEG_W-1:0] ev_start_r, ev_len_r;

  // map memory
  logic [MAP_WORDS-1:0]     vld_r;
  logic                     rd_vld_r;
  logic [WIDX_W-1:0]        raddr;
  logic [MAP_WORD_BITS-1:0] ram_q, wdata;
  logic                     ram_we;

  // output
  logic               out_valid_r;
  status_t            o_status_r;
  logic [FADDR_W-1:0] o_addr_r;
  logic [SIZE_W-1:0]  o_largest_r, o_free_r;

  logic [3:0]       shamt;
  logic [SEG_W-1:0] cnt;
  logic [3:0]       cap;

  assign shamt = granule_r ? 4'(SHIFT_LARGE) : 4'(SHIFT_SMALL);
  assign cap   = granule_r ? 4'(CAP_LARGE) : 4'(CAP_SMALL);
  assign cnt   = (32'(count_r) > NUM_SEGMENTS) ? SEG_W'(NUM_SEGMENTS) : SEG_W'(count_r);

  // ---------------- config port
  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      granule_r <= 1'b0;
      base_r    <= '0;
      count_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:3])
        CFG_IDX_GRANULE: granule_r <= cfg_pwdata[0];
        CFG_IDX_BASE:    base_r    <= cfg_pwdata[BASE_W-1:0];
        CFG_IDX_COUNT:   count_r   <= cfg_pwdata[CNT_W-1:0];
        default:         granule_r <= granule_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:3])
      CFG_IDX_GRANULE: cfg_prdata = PDATA_W'(granule_r);
      CFG_IDX_BASE:    cfg_prdata = PDATA_W'(base_r);
      CFG_IDX_COUNT:   cfg_prdata = PDATA_W'(count_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // ---------------- request checks
  logic [SEG_W-1:0]   free_segs, fidx, hi_chk;
  logic [SIZE_W-1:0]  free_bytes_now, used_bytes;
  logic [SIZE_W:0]    n_full;
  logic [SEG_W-1:0]   n_chk;
  logic [WIDE_W-1:0]  pstart, pend, addr_w;
  logic [SEG_W:0]     hi_sum;
  logic [LEN_W-1:0]   k_alloc;
  logic [3:0]         ord_alloc;
  logic [ALIGN_W-1:0] amask_chk;
  status_t            stat_chk;

  always_comb begin
    free_segs      = (cnt > used_r) ? cnt - used_r : '0;
    free_bytes_now = SIZE_W'(free_segs) << shamt;
    used_bytes     = SIZE_W'(used_r) << shamt;
    n_full    = ((SIZE_W+1)'(size_r) + (((SIZE_W+1)'(1) << shamt) - 1'b1)) >> shamt;
    n_chk     = n_full[SEG_W-1:0];
    pstart    = WIDE_W'(base_r) << shamt;
    pend      = (WIDE_W'(base_r) + WIDE_W'(cnt)) << shamt;
    addr_w    = WIDE_W'(addr_r);
    fidx      = SEG_W'((addr_r >> shamt) - FADDR_W'(base_r));
    hi_sum    = (SEG_W+1)'(fidx) + (SEG_W+1)'(n_chk);
    hi_chk    = (hi_sum > (SEG_W+1)'(cnt)) ? cnt : hi_sum[SEG_W-1:0];
    k_alloc   = bit_len(n_chk - 1'b1);
    ord_alloc = (4'(k_alloc) > cap) ? cap : 4'(k_alloc);
    amask_chk = ~({ALIGN_W{1'b1}} << ord_alloc);
    stat_chk  = ST_OK;
    priority case (req_r)
      REQ_ALLOC: begin
        if (size_r == '0 || size_r > free_bytes_now) stat_chk = ST_BAD_SIZE;
      end
      REQ_FREE: begin
        if (addr_w < pstart || addr_w > pend)         stat_chk = ST_BAD_ADDR;
        else if (size_r == '0 || size_r > used_bytes) stat_chk = ST_BAD_SIZE;
      end
      default: stat_chk = ST_OK;
    endcase
  end

  assign stat.chk_scan = ((req_r == REQ_ALLOC) && (stat_chk == ST_OK)) ||
                         ((req_r == REQ_QUERY) && (cnt != '0));
  assign stat.chk_mark = (req_r == REQ_FREE) && (stat_chk == ST_OK) && (fidx < hi_chk);

  // ---------------- scan step, one segment per cycle, paused at each map word for its fetch
  logic             bit_now, aligned, alloc_hit, p_last, q_push;
  logic [SEG_W-1:0] st, q_len, q_start;

  always_comb begin
    bit_now   = word_r[p_r[BIT_W-1:0]];
    aligned   = ((p_r[ALIGN_W-1:0] + offs_r) & amask_r) == '0;
    st        = run_r ? start_r : p_r;
    alloc_hit = (req_r == REQ_ALLOC) && !bit_now && (run_r || aligned) &&
                ((p_r - st + 1'b1) == n_r);
    p_last    = (p_r + 1'b1) == cnt;
    q_push    = (req_r == REQ_QUERY) && ((bit_now && run_r) || (!bit_now && p_last));
    q_start   = bit_now ? start_r : st;
    q_len     = bit_now ? p_r - start_r : p_r + 1'b1 - st;
  end

  assign stat.scan_last = p_last || alloc_hit;
  assign stat.word_last = &p_r[BIT_W-1:0];
  assign stat.found     = found_r;

  // ---------------- run evaluation (query)
  logic [LEN_W-1:0]   k_q;
  logic [3:0]         ord_q;
  logic [ALIGN_W-1:0] qmask, skip;
  logic [SEG_W-1:0]   adj;

  always_comb begin
    k_q = bit_len(ev_len_r - 1'b1);
    if (4'(k_q) > cap)   ord_q = cap;
    else if (k_q != '0)  ord_q = 4'(k_q) - 4'd1;
    else                 ord_q = 4'd0;
    qmask = ~({ALIGN_W{1'b1}} << ord_q);
    skip  = (ALIGN_W'(0) - ev_start_r[ALIGN_W-1:0]) & qmask;
    adj   = ev_len_r - SEG_W'(skip);
  end

  // ---------------- map update
  logic [SEG_W-1:0]         hm1;
  logic [BIT_W-1:0]         lo_b, hi_b;
  logic [MAP_WORD_BITS-1:0] mask;

  always_comb begin
    hm1   = hi_r - 1'b1;
    lo_b  = (w_r == lo_r[BIT_W +: WIDX_W]) ? lo_r[BIT_W-1:0] : '0;
    hi_b  = (w_r == hm1[BIT_W +: WIDX_W]) ? hm1[BIT_W-1:0] : '1;
    mask  = ({MAP_WORD_BITS{1'b1}} << lo_b) &
            ({MAP_WORD_BITS{1'b1}} >> (BIT_W'(MAP_WORD_BITS - 1) - hi_b));
    wdata = (req_r == REQ_ALLOC) ? (word_r | mask) : (word_r & ~mask);
  end

  assign stat.mark_last = w_r == hm1[BIT_W +: WIDX_W];
  assign ram_we = cmd.wr;
  assign raddr  = cmd.rd_mark ? w_r : p_r[BIT_W +: WIDX_W];

  absa_ram #(.WIDTH(MAP_WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // ---------------- finish
  logic             ok, alloc_ok, free_ok;
  logic [SEG_W-1:0] used_nxt, free_nxt;

  always_comb begin
    ok       = stat_r == ST_OK;
    alloc_ok = (req_r == REQ_ALLOC) && ok && found_r;
    free_ok  = (req_r == REQ_FREE) && ok && (lo_r < hi_r);
    if (alloc_ok)     used_nxt = used_r + n_r;
    else if (free_ok) used_nxt = used_r - (hi_r - lo_r);
    else              used_nxt = used_r;
    free_nxt = (cnt > used_nxt) ? cnt - used_nxt : '0;
  end

  assign stat.out_free = !out_valid_r || out_ready;

  // ---------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      ev_v_r      <= 1'b0;
    end else begin
      ev_v_r <= cmd.scan && q_push;
      if (cmd.wr) vld_r[w_r] <= 1'b1;
      if (cmd.fin) begin
        used_r      <= used_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------- payload registers
  always_ff @(posedge clk) begin
    rd_vld_r <= vld_r[raddr];
    if (cmd.load) begin
      req_r  <= req_t'(in_req_type);
      size_r <= in_size_bytes;
      addr_r <= in_free_addr;
    end
    if (cmd.check) begin
      stat_r  <= stat_chk;
      n_r     <= n_chk;
      amask_r <= amask_chk;
      offs_r  <= base_r[ALIGN_W-1:0] & amask_chk;
      lo_r    <= fidx;
      hi_r    <= hi_chk;
      w_r     <= fidx[BIT_W +: WIDX_W];
      p_r     <= '0;
      run_r   <= 1'b0;
      found_r <= 1'b0;
      best_r  <= '0;
    end
    if (cmd.ld) word_r <= rd_vld_r ? ram_q : '0;
    if (cmd.scan) begin
      p_r <= p_r + 1'b1;
      if (bit_now) begin
        run_r <= 1'b0;
      end else if (run_r || aligned || req_r == REQ_QUERY) begin
        run_r   <= 1'b1;
        start_r <= st;
      end
      if (alloc_hit) begin
        found_r <= 1'b1;
        lo_r    <= st;
        hi_r    <= st + n_r;
        w_r     <= st[BIT_W +: WIDX_W];
      end
      ev_start_r <= q_start;
      ev_len_r   <= q_len;
    end
    if (cmd.wr) w_r <= w_r + 1'b1;
    if (ev_v_r && adj > best_r) best_r <= adj;
    if (cmd.fin) begin
      o_status_r  <= ((req_r == REQ_ALLOC) && ok && !found_r) ? ST_NO_SPACE : stat_r;
      o_addr_r    <= alloc_ok ? FADDR_W'((WIDE_W'(base_r) + WIDE_W'(lo_r)) << shamt) : '0;
      o_largest_r <= (req_r == REQ_QUERY) ? (SIZE_W'(best_r) << shamt) : '0;
      o_free_r    <= SIZE_W'(free_nxt) << shamt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = o_status_r;
  assign out_alloc_addr         = o_addr_r;
  assign out_largest_free_bytes = o_largest_r;
  assign out_free_bytes         = o_free_r;

  // ---------------- checks
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= NUM_SEGMENTS)
    else $error("used segment count exceeds the map");

  a_scan_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (p_r < cnt))
    else $error("scan past the pool end");

  a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> (w_r >= lo_r[BIT_W +: WIDX_W] && w_r <= hm1[BIT_W +: WIDX_W]))
    else $error("map write outside the run");

endmodule
